// ===== rtl/unique_key_stack_defines.svh =====
// assertion macros for the unique key stack
// used at the end of the top level, needs clk and rst in scope
`ifndef UNIQUE_KEY_STACK_DEFINES_SVH
`define UNIQUE_KEY_STACK_DEFINES_SVH

// same-cycle implication
`define UKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uks_pkg.sv =====
// shared types and constants for the unique key stack
// no dependencies
`timescale 1ns / 1ps

package uks_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 5;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  out_key;
    logic signed [31:0]  out_data;
    logic [DEPTH_W-1:0]  depth_now;
    logic                is_empty;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/unique_key_stack.sv =====
// unique key stack top level: lifo of key and data pairs with duplicate check
// depends on uks_pkg and unique_key_stack_defines.svh
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid, req_stall, req) carries one request: push, pop or
//   peek. rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one item
//   per request with status, popped or top entry, count and empty flag.
//   One request is worked on at a time; req_stall is high while it runs.
//   Push: the stored keys are read one per cycle from the key memory and
//   compared; the scan ends early on a duplicate.
//   Pop and peek on a non-empty stack: one memory read.
//   Underflow and unused requests go to the finish state without a read.
//   req_stall drops in the cycle after the result is loaded.
//   The result sits in an output register; the next request is accepted
//   while it waits, and a finished request holds until the register frees.
//   A stalled rsp holds its item unchanged.
//   Reset clears the entry count, sequencer state and rsp_valid; memory contents are never cleared
//   since only entries below the count are ever read.

module unique_key_stack (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  uks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output uks_pkg::rsp_t rsp
);

  uks_pkg::state_t state, state_next;

  logic [uks_pkg::CNT_W-1:0]  count;
  logic [uks_pkg::CNT_W-1:0]  scan_idx;
  logic                       rd_pend;
  uks_pkg::req_t              req_q;

  logic [31:0] key_mem  [uks_pkg::STACK_DEPTH];
  logic [31:0] data_mem [uks_pkg::STACK_DEPTH];
  logic [31:0] key_rd;
  logic [31:0] data_rd;

  logic                        accept;
  logic                        out_free;
  logic                        is_full;
  logic                        scan_issue;
  logic                        hit;
  logic                        scan_done;
  logic                        rd_en;
  logic [uks_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic                        load;
  logic [uks_pkg::CNT_W-1:0]   count_after;
  uks_pkg::rsp_t               rsp_next;

  assign req_stall  = (state != uks_pkg::S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign is_full    = (count == uks_pkg::CNT_W'(uks_pkg::STACK_DEPTH));
  assign scan_issue = (scan_idx < count);
  assign hit        = rd_pend && (key_rd == req_q.key);
  assign scan_done  = hit || (!scan_issue && !rd_pend);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      uks_pkg::S_IDLE: begin
        if (accept) begin
          if (req.op == uks_pkg::OP_PUSH) begin
            state_next = uks_pkg::S_SCAN;
          end else if ((req.op == uks_pkg::OP_POP || req.op == uks_pkg::OP_PEEK)
                       && count != '0) begin
            state_next = uks_pkg::S_READ;
          end else begin
            state_next = uks_pkg::S_FINISH;
          end
        end
      end
      uks_pkg::S_SCAN: begin
        if (scan_done && out_free) state_next = uks_pkg::S_IDLE;
      end
      uks_pkg::S_READ,
      uks_pkg::S_FINISH: begin
        if (out_free) state_next = uks_pkg::S_IDLE;
      end
      default: state_next = uks_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    load        = 1'b0;
    count_after = count;
    rsp_next    = '0;
    rsp_next.status = uks_pkg::ST_OK;
    unique case (state)
      uks_pkg::S_IDLE: begin
        if (accept && (req.op == uks_pkg::OP_POP || req.op == uks_pkg::OP_PEEK)
            && count != '0) begin
          rd_en   = 1'b1;
          rd_addr = uks_pkg::ADDR_W'(count - 1'b1);
        end
      end
      uks_pkg::S_SCAN: begin
        if (!scan_done) begin
          rd_en   = scan_issue;
          rd_addr = uks_pkg::ADDR_W'(scan_idx);
        end else if (out_free) begin
          load = 1'b1;
          if (hit) begin
            rsp_next.status = uks_pkg::ST_DUP;
          end else if (is_full) begin
            rsp_next.status = uks_pkg::ST_OVER;
          end else begin
            wr_en       = 1'b1;
            count_after = count + 1'b1;
          end
        end
      end
      uks_pkg::S_READ: begin
        load              = out_free;
        rsp_next.out_key  = key_rd;
        rsp_next.out_data = data_rd;
        if (req_q.op == uks_pkg::OP_POP) count_after = count - 1'b1;
      end
      uks_pkg::S_FINISH: begin
        load = out_free;
        if (req_q.op == uks_pkg::OP_POP || req_q.op == uks_pkg::OP_PEEK) begin
          rsp_next.status = uks_pkg::ST_UNDER;
        end
      end
      default: ;
    endcase
    rsp_next.depth_now = uks_pkg::DEPTH_W'(count_after);
    rsp_next.is_empty  = (count_after == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= uks_pkg::S_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) count <= count_after;
      if (accept) begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
      end else if (state == uks_pkg::S_SCAN && !scan_done) begin
        rd_pend  <= scan_issue;
        scan_idx <= scan_idx + uks_pkg::CNT_W'(scan_issue);
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    if (load) rsp <= rsp_next;
  end

  // key and data memories, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[uks_pkg::ADDR_W'(count)]  <= req_q.key;
      data_mem[uks_pkg::ADDR_W'(count)] <= req_q.data;
    end
    if (rd_en) begin
      key_rd  <= key_mem[rd_addr];
      data_rd <= data_mem[rd_addr];
    end
  end

`include "unique_key_stack_defines.svh"

  `UKS_ASSERT_NOW(a_count_bound, 1'b1, count <= uks_pkg::CNT_W'(uks_pkg::STACK_DEPTH), "count beyond depth")
  `UKS_ASSERT_NOW(a_write_not_full, wr_en, !is_full && !hit, "write into full stack or on duplicate")
  `UKS_ASSERT_NOW(a_read_below_count, rd_en, uks_pkg::CNT_W'(rd_addr) < count, "read of unfilled entry")
  `UKS_ASSERT_NEXT(a_dup_keeps_count, load && rsp_next.status == uks_pkg::ST_DUP, count == $past(count), "duplicate changed count")
  `UKS_ASSERT_NEXT(a_pop_decrements, load && state == uks_pkg::S_READ && req_q.op == uks_pkg::OP_POP, count == uks_pkg::CNT_W'($past(count) - 1'b1), "pop did not decrement")

endmodule
